>>> rtl/core/ict_pkg.sv
// ict_pkg: shared types and codes for the interval coverage tracker.
// Used by ict_cell and interval_coverage_tracker; no dependencies.
`timescale 1ns / 1ps
package ict_pkg;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BEFORE   = 3'd1,
    STAT_TOO_LONG = 3'd2,
    STAT_BEYOND   = 3'd3,
    STAT_OVERLAP  = 3'd4,
    STAT_FULL     = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_OUT
  } state_t;

  localparam logic KIND_CLEAR = 1'b0;

  localparam logic [1:0] REG_PAYLOAD_UNITS   = 2'd0;
  localparam logic [1:0] REG_MAX_CHUNK_UNITS = 2'd1;

  localparam logic [16:0] PAYLOAD_RESET   = 17'd65536;
  localparam logic [15:0] MAX_CHUNK_RESET = 16'hFFFF;

  // chunk bounds broadcast to every cell
  typedef struct packed {
    logic [15:0] b;
    logic [16:0] e;
  } bcast_t;

  // action applied to every cell of the chain together
  typedef struct packed {
    logic cmp;
    logic ins;
    logic bridge;
    logic ext_s;
    logic ext_e;
  } cmd_t;

  // neighbor tests, driven only by the cell that holds the last start <= e
  typedef struct packed {
    logic after;
    logic s_eq;
    logic p_gt;
    logic p_eq;
    logic e_eq;
  } flags_t;

endpackage

>>> rtl/core/interval_coverage_tracker.sv
// Interval coverage tracker: compare, update and result load steps run in order
// over the cell chain, with the checks taken at accept. A new transaction is
// accepted only once the last one has left its result load step; a stalled result
// holds the next transaction in its load step. All cells compare in parallel.
// Synchronous reset empties the set and loads the register reset values.
// Depends on ict_pkg and ict_cell.
`timescale 1ns / 1ps
module interval_coverage_tracker #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [16:0] chunk_offset,
  input  logic [15:0] chunk_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] first_start,
  output logic [16:0] last_end,
  output logic [8:0]  interval_count
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  logic [16:0] payload_units;
  logic [15:0] max_chunk_units;
  ict_pkg::state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  ict_pkg::stat_t chk;
  ict_pkg::stat_t stat_next;
  logic is_clear;
  logic is_zero;
  ict_pkg::bcast_t bc;
  ict_pkg::cmd_t cmd;
  ict_pkg::flags_t red;

  logic [15:0] cs [MAX_INTERVALS];
  logic [16:0] ce [MAX_INTERVALS];
  logic        le [MAX_INTERVALS];
  logic        here [MAX_INTERVALS];
  logic        occ [MAX_INTERVALS];
  ict_pkg::flags_t flg [MAX_INTERVALS];
  logic [16:0] last_e;
  logic [CW+8:0] cnt_ext;

  logic        in_acc;
  logic        out_load;
  logic [17:0] end_sum;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ict_pkg::ST_IDLE);
  assign out_load = (state == ict_pkg::ST_OUT) && (!out_valid || !out_stall);
  assign end_sum  = {1'b0, chunk_offset} + {2'b00, chunk_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_units   <= ict_pkg::PAYLOAD_RESET;
      max_chunk_units <= ict_pkg::MAX_CHUNK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ict_pkg::REG_PAYLOAD_UNITS:   payload_units <= cfg_data;
        ict_pkg::REG_MAX_CHUNK_UNITS: max_chunk_units <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // checks and chunk bounds are latched with the transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_clear <= (kind == ict_pkg::KIND_CLEAR);
      is_zero  <= (chunk_len == 16'd0);
      bc.b     <= chunk_offset[15:0];
      bc.e     <= end_sum[16:0];
      if (chunk_offset[16]) begin
        chk <= ict_pkg::STAT_BEFORE;
      end else if (chunk_len > max_chunk_units) begin
        chk <= ict_pkg::STAT_TOO_LONG;
      end else if (end_sum > {1'b0, payload_units}) begin
        chk <= ict_pkg::STAT_BEYOND;
      end else begin
        chk <= ict_pkg::STAT_OK;
      end
    end
  end

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    assign occ[i] = (CW'(i) < count);
    ict_cell #(.FIRST(i == 0)) u_cell (
      .clk       (clk),
      .bc        (bc),
      .cmd       (cmd),
      .occ       (occ[i]),
      .le_prev   ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .le_next   ((i == MAX_INTERVALS - 1) ? 1'b0 :
                  le[(i == MAX_INTERVALS - 1) ? i : i + 1]),
      .here_next ((i == MAX_INTERVALS - 1) ? 1'b0 :
                  here[(i == MAX_INTERVALS - 1) ? i : i + 1]),
      .prv_start ((i == 0) ? 16'd0 : cs[(i == 0) ? 0 : i - 1]),
      .prv_end   ((i == 0) ? 17'd0 : ce[(i == 0) ? 0 : i - 1]),
      .nxt_start ((i == MAX_INTERVALS - 1) ? 16'd0 :
                  cs[(i == MAX_INTERVALS - 1) ? i : i + 1]),
      .nxt_end   ((i == MAX_INTERVALS - 1) ? 17'd0 :
                  ce[(i == MAX_INTERVALS - 1) ? i : i + 1]),
      .ival_s    (cs[i]),
      .ival_e    (ce[i]),
      .le        (le[i]),
      .here      (here[i]),
      .flg       (flg[i])
    );
  end

  always_comb begin
    red    = '0;
    last_e = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      red = red | flg[i];
      if (occ[i] &&
          ((i == MAX_INTERVALS - 1) || !occ[(i == MAX_INTERVALS - 1) ? i : i + 1])) begin
        last_e = last_e | ce[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ict_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    stat_next  = chk;
    unique case (state)
      ict_pkg::ST_IDLE: begin
        if (in_acc) state_next = ict_pkg::ST_CMP;
      end
      ict_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ict_pkg::ST_UPD;
      end
      ict_pkg::ST_UPD: begin
        state_next = ict_pkg::ST_OUT;
        if (is_clear) begin
          stat_next  = ict_pkg::STAT_OK;
          count_next = '0;
        end else if (chk == ict_pkg::STAT_OK && !is_zero) begin
          // no held start <= e, or the last such interval ends before b
          if (!le[0] || red.after) begin
            if (count >= CW'(MAX_INTERVALS)) begin
              stat_next = ict_pkg::STAT_FULL;
            end else begin
              cmd.ins    = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (red.s_eq) begin
            if (red.p_gt) begin
              stat_next = ict_pkg::STAT_OVERLAP;
            end else if (red.p_eq) begin
              cmd.bridge = 1'b1;
              count_next = count - CW'(1);
            end else begin
              cmd.ext_s = 1'b1;
            end
          end else if (red.e_eq) begin
            cmd.ext_e = 1'b1;
          end else begin
            stat_next = ict_pkg::STAT_OVERLAP;
          end
        end
      end
      ict_pkg::ST_OUT: begin
        // wait here while the previous result is still stalled
        if (out_load) state_next = ict_pkg::ST_IDLE;
      end
      default: state_next = ict_pkg::ST_IDLE;
    endcase
  end

  logic [2:0] stat_hold;
  always_ff @(posedge clk) begin
    if (state == ict_pkg::ST_UPD) stat_hold <= stat_next;
  end

  assign cnt_ext = {9'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= stat_hold;
      first_start    <= (count != '0) ? cs[0] : 16'd0;
      last_end       <= last_e;
      interval_count <= cnt_ext[8:0];
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INTERVALS))
    else $error("interval count above table size");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cmp, cmd.ins, cmd.bridge, cmd.ext_s, cmd.ext_e}))
    else $error("more than one chain action");

  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == ict_pkg::ST_OUT |=> out_valid)
    else $error("result not presented");

  a_acc_cmp: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ict_pkg::ST_CMP)
    else $error("accepted transaction not started");

endmodule

>>> rtl/core/ict_cell.sv
// ict_cell: one entry of the sorted interval chain with its local compares.
// Depends on ict_pkg.
`timescale 1ns / 1ps
module ict_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic            clk,
  input  ict_pkg::bcast_t bc,
  input  ict_pkg::cmd_t   cmd,
  input  logic            occ,
  input  logic            le_prev,
  input  logic            le_next,
  input  logic            here_next,
  input  logic [15:0]     prv_start,
  input  logic [16:0]     prv_end,
  input  logic [15:0]     nxt_start,
  input  logic [16:0]     nxt_end,
  output logic [15:0]     ival_s,
  output logic [16:0]     ival_e,
  output logic            le,
  output logic            here,
  output ict_pkg::flags_t flg
);

  assign here = le && !le_next;

  always_comb begin
    flg       = '0;
    flg.after = here && (ival_e < {1'b0, bc.b});
    flg.s_eq  = here && ({1'b0, ival_s} == bc.e);
    flg.p_gt  = here && !FIRST && (prv_end > {1'b0, bc.b});
    flg.p_eq  = here && !FIRST && (prv_end == {1'b0, bc.b});
    flg.e_eq  = here && (ival_e == {1'b0, bc.b});
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      le <= occ && ({1'b0, ival_s} <= bc.e);
    end
    if (cmd.ins) begin
      if (!le && le_prev) begin
        ival_s <= bc.b;
        ival_e <= bc.e;
      end else if (!le_prev) begin
        ival_s <= prv_start;
        ival_e <= prv_end;
      end
    end
    if (cmd.bridge) begin
      if (!le_next) begin
        ival_s <= nxt_start;
        ival_e <= nxt_end;
      end else if (here_next) begin
        ival_e <= nxt_end;
      end
    end
    if (cmd.ext_s && here) begin
      ival_s <= bc.b;
    end
    if (cmd.ext_e && here) begin
      ival_e <= bc.e;
    end
  end

endmodule
